/* hw/rtl/fsca_pkg.sv */
// Shared types, codes and the cell update rule of the fire spread automaton.
package fsca_pkg;

    typedef logic [1:0] cell_t;
    typedef logic [1:0] opcode_t;

    localparam int COORD_W = 5;
    typedef logic [COORD_W-1:0] coord_t;

    localparam opcode_t OP_WRITE = 2'd0;
    localparam opcode_t OP_READ  = 2'd1;
    localparam opcode_t OP_STEP  = 2'd2;

    localparam cell_t CELL_INTACT  = 2'd0;
    localparam cell_t CELL_BURNING = 2'd1;
    localparam cell_t CELL_BURNED  = 2'd2;

    // Classified command: coordinates already wrapped onto the grid, value saturated
    typedef struct packed {
        opcode_t op;
        coord_t  row;
        coord_t  col;
        cell_t   value;
    } cmd_t;

    // Intact catches fire from any burning neighbor, burning burns out
    function automatic cell_t next_cell(input cell_t center, input logic fire_near);
        cell_t result;
        if (center == CELL_INTACT && fire_near)
        begin
            result = CELL_BURNING;
        end
        else if (center == CELL_BURNING)
        begin
            result = CELL_BURNED;
        end
        else
        begin
            result = center;
        end
        return result;
    endfunction

endpackage

/* hw/rtl/fsca_if.sv */
// Valid/ready channel interfaces for commands and responses.
interface fsca_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] opcode;
    logic [4:0] row;
    logic [4:0] col;
    logic [1:0] cell_value;

    modport source (output valid, output opcode, output row, output col,
                    output cell_value, input ready);
    modport sink   (input valid, input opcode, input row, input col,
                    input cell_value, output ready);
endinterface

interface fsca_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] cell_state;
    logic [1:0] op_done;

    modport source (output valid, output cell_state, output op_done, input ready);
    modport sink   (input valid, input cell_state, input op_done, output ready);
endinterface

/* hw/rtl/fsca_front.sv */
// Command front end: accept, classify and queue commands for the engine.
module fsca_front #(
    parameter int GRID_SIDE = 32
) (
    input  logic           clk,
    input  logic           rst_n,
    fsca_in_if.sink        cmd,
    input  logic           hold,
    output fsca_pkg::cmd_t q_cmd,
    output logic           q_valid,
    input  logic           q_ready
);
    import fsca_pkg::*;

    localparam int TBL_N = 2 ** COORD_W;

    coord_t     wrap_tbl [TBL_N];
    cmd_t       q_mem_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       accept;
    logic       push;
    logic       pop;
    cmd_t       entry;

    // Wrap table: coordinate modulo grid side, folded at elaboration
    for (genvar i = 0; i < TBL_N; i++)
    begin : g_wrap
        assign wrap_tbl[i] = COORD_W'(i % GRID_SIDE);
    end

    assign cmd.ready = (count_reg != 2'd2) && !hold;
    assign accept    = cmd.valid && cmd.ready;
    // Drop the unused opcode
    assign push      = accept && (cmd.opcode == OP_WRITE || cmd.opcode == OP_READ ||
                                  cmd.opcode == OP_STEP);
    assign q_valid   = (count_reg != 2'd0);
    assign pop       = q_valid && q_ready;
    assign q_cmd     = q_mem_reg[rd_ptr_reg];

    always_comb
    begin
        entry.op    = cmd.opcode;
        entry.row   = wrap_tbl[cmd.row];
        entry.col   = wrap_tbl[cmd.col];
        entry.value = (cmd.cell_value > CELL_BURNED) ? CELL_BURNED : cmd.cell_value;
    end

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem_reg[wr_ptr_reg] <= entry;
        end
    end

endmodule

/* hw/rtl/fsca_back.sv */
// Command engine: grid memory, clearing pass, cell access and generation sweep.
module fsca_back #(
    parameter int GRID_SIDE = 32
) (
    input  logic           clk,
    input  logic           rst_n,
    input  fsca_pkg::cmd_t q_cmd,
    input  logic           q_valid,
    output logic           q_ready,
    output logic           clearing,
    fsca_out_if.source     rsp
);
    import fsca_pkg::*;

    localparam int RW    = $clog2(GRID_SIDE);
    localparam int W     = GRID_SIDE + 2;
    localparam int PW    = $clog2(W);
    localparam int AW    = 2 * RW + 1;
    localparam int DEPTH = 2 ** AW;
    localparam int SHL   = 2 * W + 2;
    localparam int CLR_W = 2 * RW;

    typedef enum logic [4:0] {
        ST_CLEAR = 5'b00001,
        ST_IDLE  = 5'b00010,
        ST_READ  = 5'b00100,
        ST_SWEEP = 5'b01000,
        ST_DRAIN = 5'b10000
    } state_t;

    cell_t             grid_mem [DEPTH];
    cell_t             rd_data_reg;
    cell_t             sr_reg [SHL];

    state_t            state_reg;
    state_t            state_next;
    logic              active_reg;
    logic              active_next;
    logic [PW-1:0]     pr_reg;
    logic [PW-1:0]     pr_next;
    logic [PW-1:0]     pc_reg;
    logic [PW-1:0]     pc_next;
    logic [CLR_W-1:0]  clr_reg;
    logic [CLR_W-1:0]  clr_next;
    logic              tag_valid_reg;
    logic              tag_valid_next;
    logic [PW-1:0]     tag_pr_reg;
    logic [PW-1:0]     tag_pr_next;
    logic [PW-1:0]     tag_pc_reg;
    logic [PW-1:0]     tag_pc_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    cell_t             out_state_reg;
    cell_t             out_state_next;
    opcode_t           out_op_reg;
    opcode_t           out_op_next;

    logic              out_free;
    logic              take;
    logic [RW-1:0]     cmd_row;
    logic [RW-1:0]     cmd_col;
    logic              fire_near;
    cell_t             center;
    logic              sweep_wr;
    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    cell_t             mem_wdata;
    logic [AW-1:0]     mem_raddr;

    // Padded sweep coordinate to grid coordinate, wrapping both borders
    function automatic logic [RW-1:0] pad_to_real(input logic [PW-1:0] p);
        logic [RW-1:0] r;
        if (p == '0)
        begin
            r = RW'(GRID_SIDE - 1);
        end
        else if (p == PW'(W - 1))
        begin
            r = '0;
        end
        else
        begin
            r = RW'(p - PW'(1));
        end
        return r;
    endfunction

    assign out_free  = !out_valid_reg || rsp.ready;
    assign q_ready   = (state_reg == ST_IDLE) && out_free;
    assign take      = q_valid && q_ready;
    assign cmd_row   = RW'(q_cmd.row);
    assign cmd_col   = RW'(q_cmd.col);
    assign clearing  = (state_reg == ST_CLEAR);

    assign rsp.valid      = out_valid_reg;
    assign rsp.cell_state = out_state_reg;
    assign rsp.op_done    = out_op_reg;

    // 3x3 window: newest sample is rd_data_reg, k samples back is sr_reg[k-1]
    assign center    = sr_reg[W];
    assign fire_near = (rd_data_reg   == CELL_BURNING) || (sr_reg[0]     == CELL_BURNING) ||
                       (sr_reg[1]     == CELL_BURNING) || (sr_reg[W-1]   == CELL_BURNING) ||
                       (sr_reg[W+1]   == CELL_BURNING) || (sr_reg[2*W-1] == CELL_BURNING) ||
                       (sr_reg[2*W]   == CELL_BURNING) || (sr_reg[2*W+1] == CELL_BURNING);
    assign sweep_wr  = tag_valid_reg && (tag_pr_reg >= PW'(2)) && (tag_pc_reg >= PW'(2));

    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = {active_reg, cmd_row, cmd_col};
        mem_wdata = q_cmd.value;
        priority if (state_reg == ST_CLEAR)
        begin
            mem_we    = 1'b1;
            mem_waddr = {1'b0, clr_reg};
            mem_wdata = CELL_INTACT;
        end
        else if (sweep_wr)
        begin
            mem_we    = 1'b1;
            mem_waddr = {~active_reg, RW'(tag_pr_reg - PW'(2)), RW'(tag_pc_reg - PW'(2))};
            mem_wdata = next_cell(center, fire_near);
        end
        else if (take && q_cmd.op == OP_WRITE)
        begin
            mem_we = 1'b1;
        end
        else
        begin
            mem_we = 1'b0;
        end
    end

    always_comb
    begin
        if (state_reg == ST_SWEEP)
        begin
            mem_raddr = {active_reg, pad_to_real(pr_reg), pad_to_real(pc_reg)};
        end
        else
        begin
            mem_raddr = {active_reg, cmd_row, cmd_col};
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        active_next    = active_reg;
        pr_next        = pr_reg;
        pc_next        = pc_reg;
        clr_next       = clr_reg;
        tag_valid_next = 1'b0;
        tag_pr_next    = pr_reg;
        tag_pc_next    = pc_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        out_state_next = out_state_reg;
        out_op_next    = out_op_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                clr_next = clr_reg + CLR_W'(1);
                if (&clr_reg)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (take)
                begin
                    priority if (q_cmd.op == OP_WRITE)
                    begin
                        out_valid_next = 1'b1;
                        out_state_next = q_cmd.value;
                        out_op_next    = OP_WRITE;
                    end
                    else if (q_cmd.op == OP_READ)
                    begin
                        state_next = ST_READ;
                    end
                    else
                    begin
                        state_next = ST_SWEEP;
                        pr_next    = '0;
                        pc_next    = '0;
                    end
                end
            end
            ST_READ:
            begin
                out_valid_next = 1'b1;
                out_state_next = rd_data_reg;
                out_op_next    = OP_READ;
                state_next     = ST_IDLE;
            end
            ST_SWEEP:
            begin
                tag_valid_next = 1'b1;
                if (pc_reg == PW'(W - 1))
                begin
                    pc_next = '0;
                    pr_next = pr_reg + PW'(1);
                    if (pr_reg == PW'(W - 1))
                    begin
                        state_next = ST_DRAIN;
                    end
                end
                else
                begin
                    pc_next = pc_reg + PW'(1);
                end
            end
            ST_DRAIN:
            begin
                out_valid_next = 1'b1;
                out_state_next = CELL_INTACT;
                out_op_next    = OP_STEP;
                active_next    = ~active_reg;
                state_next     = ST_IDLE;
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            active_reg    <= 1'b0;
            pr_reg        <= '0;
            pc_reg        <= '0;
            clr_reg       <= '0;
            tag_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            active_reg    <= active_next;
            pr_reg        <= pr_next;
            pc_reg        <= pc_next;
            clr_reg       <= clr_next;
            tag_valid_reg <= tag_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tag_pr_reg    <= tag_pr_next;
        tag_pc_reg    <= tag_pc_next;
        out_state_reg <= out_state_next;
        out_op_reg    <= out_op_next;
    end

    // Grid memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            grid_mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= grid_mem[mem_raddr];
    end

    // Window line: two padded rows plus two samples
    always_ff @(posedge clk)
    begin
        if (tag_valid_reg)
        begin
            sr_reg[0] <= rd_data_reg;
            for (int i = 1; i < SHL; i++)
            begin
                sr_reg[i] <= sr_reg[i-1];
            end
        end
    end

endmodule

/* hw/rtl/fire_spread_cellular_automaton.sv */
// Forest fire cellular automaton on a toroidal GRID_SIDE x GRID_SIDE grid.
//
// Commands arrive as beats on cmd: write a cell, read a cell, or advance one
// generation; every write, read and advance returns one beat on rsp carrying
// the stored or read state (zero for an advance) and the echoed opcode.
// Opcode 3 is taken and dropped without a response. Coordinates wrap modulo
// GRID_SIDE and a written value of 3 is stored as burned. The front end
// queues up to two commands, so cmd keeps taking beats while the engine works
// or rsp stalls. In the engine a write goes to the grid memory and the response
// register together, a read goes through the registered read port of the grid
// memory, and an advance runs a sweep that streams the active bank through
// the single read port one cell per cycle, with the wrapped border rows and
// columns read again, and writes each new cell to the other bank; the banks
// then swap. A response waits in an output register, and the engine starts
// the next command only once it can be taken. After reset a clearing pass
// writes every cell of the current bank to intact, and cmd stays not ready
// until it ends.
module fire_spread_cellular_automaton #(
    parameter int GRID_SIDE = 32
) (
    input  logic       clk,
    input  logic       rst_n,
    fsca_in_if.sink    cmd,
    fsca_out_if.source rsp
);
    import fsca_pkg::*;

    cmd_t q_cmd;
    logic q_valid;
    logic q_ready;
    logic clearing;

    // Front end: take beats, drop the unused opcode, wrap and saturate, queue
    fsca_front #(
        .GRID_SIDE (GRID_SIDE)
    ) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .hold    (clearing),
        .q_cmd   (q_cmd),
        .q_valid (q_valid),
        .q_ready (q_ready)
    );

    // Engine: grid banks, generation sweep and response register
    fsca_back #(
        .GRID_SIDE (GRID_SIDE)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_cmd    (q_cmd),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .clearing (clearing),
        .rsp      (rsp)
    );

endmodule

/* hw/rtl/fsca_checker.sv */
// Port-level checks of the fire spread automaton, bound to the top level.
module fsca_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       cmd_valid,
    input logic       cmd_ready,
    input logic       rsp_valid,
    input logic       rsp_ready,
    input logic [1:0] cell_state,
    input logic [1:0] op_done
);
    import fsca_pkg::*;

    a_op_known: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (op_done == OP_WRITE || op_done == OP_READ || op_done == OP_STEP))
        else $error("response echoes an unused opcode");

    a_state_known: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (cell_state == CELL_INTACT || cell_state == CELL_BURNING ||
                       cell_state == CELL_BURNED))
        else $error("response carries an invalid cell state");

    a_step_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && op_done == OP_STEP) |-> (cell_state == CELL_INTACT))
        else $error("generation response is not zero");

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(cell_state) && $stable(op_done)))
        else $error("stalled response changed");

    a_clear_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> !cmd_ready)
        else $error("command taken during the clearing pass");

endmodule

bind fire_spread_cellular_automaton fsca_checker u_fsca_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd_valid  (cmd.valid),
    .cmd_ready  (cmd.ready),
    .rsp_valid  (rsp.valid),
    .rsp_ready  (rsp.ready),
    .cell_state (rsp.cell_state),
    .op_done    (rsp.op_done)
);

/* tb/tb_top.sv */
// Testbench of the fire spread automaton: directed and random commands checked against a grid predictor.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import fsca_pkg::*;

    // Grid side of the instance; the block wraps coordinates modulo this.
    localparam int SIDE = 32;
    // Wait budget for one generation, built on the sweep of (SIDE+2)^2 padded cells.
    localparam int STEP_CYCLES = (SIDE + 2) * (SIDE + 2) + 2;
    // Opcode the block takes and drops without a response.
    localparam opcode_t OP_UNUSED = 2'd3;
    // Out-of-range write value, stored as burned.
    localparam cell_t CELL_OVERFLOW = 2'd3;
    // Number of command beats the random part aims for (drops not counted).
    localparam int RANDOM_BEATS = 560;
    // Cycles the response side holds off during the backpressure test.
    localparam int HOLD_OFF_CYCLES = 400;

    typedef struct {
        cell_t   state;
        opcode_t op;
    } rsp_beat_t;

    logic clk;
    logic rst_n;

    fsca_in_if  cmd_if();
    fsca_out_if rsp_if();

    fire_spread_cellular_automaton #(
        .GRID_SIDE(SIDE)
    ) i_dut (
        .clk  (clk),
        .rst_n(rst_n),
        .cmd  (cmd_if),
        .rsp  (rsp_if)
    );

    // Predicted grid as seen from outside: the active bank only. The other
    // bank is rewritten in full by every generation, so it never shows.
    cell_t     fire_grid[SIDE][SIDE];
    // Responses the block owes, oldest first.
    rsp_beat_t pending_rsp[$];

    // Set to suppress idling on both sides for a stretch.
    bit steady;
    // Request a hold-off of this many cycles from the response side.
    int rsp_hold_cycles;

    int n_errors;
    int n_writes;
    int n_reads;
    int n_steps;
    int n_dropped;
    int n_checked;
    int n_scenes;

    // Clock: 4 ns period.
    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    task automatic report_mismatch(input string msg);
        n_errors++;
        $display("[%0t] MISMATCH: %s", $realtime, msg);
    endtask

    // Advance the predicted grid by one generation, every cell from the old grid.
    function automatic void burn_generation();
        cell_t old_grid[SIDE][SIDE];
        logic  fire_near;
        int    nr;
        int    nc;
        old_grid = fire_grid;
        for (int r = 0; r < SIDE; r++)
        begin
            for (int c = 0; c < SIDE; c++)
            begin
                fire_near = 1'b0;
                for (int dr = -1; dr <= 1; dr++)
                begin
                    for (int dc = -1; dc <= 1; dc++)
                    begin
                        nr = (r + dr + SIDE) % SIDE;
                        nc = (c + dc + SIDE) % SIDE;
                        if ((dr != 0 || dc != 0) && old_grid[nr][nc] == CELL_BURNING)
                        begin
                            fire_near = 1'b1;
                        end
                    end
                end
                if (old_grid[r][c] == CELL_INTACT && fire_near)
                begin
                    fire_grid[r][c] = CELL_BURNING;
                end
                else if (old_grid[r][c] == CELL_BURNING)
                begin
                    fire_grid[r][c] = CELL_BURNED;
                end
            end
        end
    endfunction

    // Apply one accepted command to the predicted grid and queue its response.
    function automatic void predict_cmd(input opcode_t op, input coord_t row,
                                        input coord_t col, input cell_t value);
        rsp_beat_t beat;
        int        r;
        int        c;
        r = row % SIDE;
        c = col % SIDE;
        case (op)
            OP_WRITE:
            begin
                // Saturate an out-of-range value to burned.
                if (value > CELL_BURNED)
                begin
                    value = CELL_BURNED;
                end
                fire_grid[r][c] = value;
                beat.state = value;
                beat.op = OP_WRITE;
                pending_rsp.push_back(beat);
                n_writes++;
            end
            OP_READ:
            begin
                beat.state = fire_grid[r][c];
                beat.op = OP_READ;
                pending_rsp.push_back(beat);
                n_reads++;
            end
            OP_STEP:
            begin
                burn_generation();
                beat.state = '0;
                beat.op = OP_STEP;
                pending_rsp.push_back(beat);
                n_steps++;
            end
            default:
            begin
                // Unused opcode: taken, no response.
                n_dropped++;
            end
        endcase
    endfunction

    // Offer one command beat and hold it until the block takes it. Call at a
    // rising edge; valid stays high on return so back-to-back beats need no
    // second assignment in the same step.
    task automatic send_cmd(input opcode_t op, input coord_t row, input coord_t col,
                            input cell_t value);
        int gap;
        gap = 0;
        if (!steady && $urandom_range(0, 99) < 14)
        begin
            gap = $urandom_range(1, 4);
        end
        if (gap > 0)
        begin
            cmd_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_if.valid      <= 1'b1;
        cmd_if.opcode     <= op;
        cmd_if.row        <= row;
        cmd_if.col        <= col;
        cmd_if.cell_value <= value;
        do
            @(posedge clk);
        while (cmd_if.ready !== 1'b1);
        predict_cmd(op, row, col, value);
    endtask

    // Drop valid and wait until every owed response has come back.
    task automatic drain_responses();
        cmd_if.valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_rsp.size() != 0);
    endtask

    // Write value biased toward burning so fires start often.
    function automatic cell_t fire_value();
        if ($urandom_range(0, 1) == 1)
        begin
            return CELL_BURNING;
        end
        return cell_t'($urandom_range(0, 3));
    endfunction

    // Response side: accept with random stalls, or hold off on request for a
    // counted stretch.
    initial
    begin : rsp_drive
        int hold;
        rsp_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rsp_hold_cycles > 0)
            begin
                hold = rsp_hold_cycles;
                rsp_hold_cycles = 0;
                rsp_if.ready <= 1'b0;
                repeat (hold) @(posedge clk);
            end
            else
            begin
                rsp_if.ready <= steady || ($urandom_range(0, 99) >= 14);
            end
        end
    end

    // Compare every accepted response beat with the oldest prediction.
    always @(posedge clk)
    begin : rsp_check
        rsp_beat_t want;
        if (rst_n === 1'b1 && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1)
        begin
            n_checked++;
            if (pending_rsp.size() == 0)
            begin
                report_mismatch($sformatf("unexpected response cell_state=%0d op_done=%0d",
                                          rsp_if.cell_state, rsp_if.op_done));
            end
            else
            begin
                want = pending_rsp.pop_front();
                if (rsp_if.op_done !== want.op)
                begin
                    report_mismatch($sformatf("op_done %0d, predicted %0d",
                                              rsp_if.op_done, want.op));
                end
                if (rsp_if.cell_state !== want.state)
                begin
                    report_mismatch($sformatf("cell_state %0d, predicted %0d (op %0d)",
                                              rsp_if.cell_state, want.state, want.op));
                end
            end
        end
    end

    // The clearing pass must leave intact cells at the far corners.
    task automatic test_reset_state();
        send_cmd(OP_READ, 5'd0, 5'd0, CELL_INTACT);
        send_cmd(OP_READ, 5'd31, 5'd31, CELL_BURNED);
    endtask

    // Write every value, the out-of-range one included, at the four corners
    // and read each back.
    task automatic test_write_read_extremes();
        send_cmd(OP_WRITE, 5'd0, 5'd0, CELL_BURNING);
        send_cmd(OP_WRITE, 5'd31, 5'd31, CELL_BURNED);
        send_cmd(OP_WRITE, 5'd0, 5'd31, CELL_OVERFLOW);
        send_cmd(OP_WRITE, 5'd31, 5'd0, CELL_INTACT);
        send_cmd(OP_READ, 5'd0, 5'd0, CELL_INTACT);
        send_cmd(OP_READ, 5'd31, 5'd31, CELL_INTACT);
        send_cmd(OP_READ, 5'd0, 5'd31, CELL_INTACT);
        send_cmd(OP_READ, 5'd31, 5'd0, CELL_OVERFLOW);
    endtask

    // An unused opcode must be swallowed with no response and no grid change.
    task automatic test_unused_opcode();
        send_cmd(OP_UNUSED, 5'd0, 5'd0, CELL_INTACT);
        send_cmd(OP_READ, 5'd0, 5'd0, CELL_INTACT);
    endtask

    // Fire at a corner must spread across the wrapped row border; burned cells stay.
    task automatic test_wrapping_spread();
        send_cmd(OP_STEP, 5'd31, 5'd31, CELL_OVERFLOW);
        send_cmd(OP_READ, 5'd0, 5'd0, CELL_INTACT);
        send_cmd(OP_READ, 5'd31, 5'd0, CELL_INTACT);
        send_cmd(OP_READ, 5'd1, 5'd1, CELL_INTACT);
        send_cmd(OP_READ, 5'd31, 5'd31, CELL_INTACT);
        send_cmd(OP_READ, 5'd30, 5'd30, CELL_INTACT);
        send_cmd(OP_STEP, 5'd0, 5'd0, CELL_INTACT);
        send_cmd(OP_READ, 5'd30, 5'd1, CELL_INTACT);
    endtask

    // Stall the response side long enough that the command queue fills and
    // cmd stops taking beats, then pause the sender until all responses drain.
    task automatic test_backpressure();
        rsp_hold_cycles = HOLD_OFF_CYCLES;
        for (int k = 0; k < 12; k++)
        begin
            if (k % 2 == 0)
            begin
                send_cmd(OP_WRITE, coord_t'($urandom_range(0, 31)),
                         coord_t'($urandom_range(0, 31)), fire_value());
            end
            else
            begin
                send_cmd(OP_READ, coord_t'($urandom_range(0, 31)),
                         coord_t'($urandom_range(0, 31)), CELL_INTACT);
            end
        end
        drain_responses();
        send_cmd(OP_STEP, 5'd0, 5'd0, CELL_INTACT);
        send_cmd(OP_READ, coord_t'($urandom_range(0, 31)),
                 coord_t'($urandom_range(0, 31)), CELL_INTACT);
    endtask

    // Random scenes: seed a small cluster of cells, maybe burn a generation or two,
    // then probe the neighborhood. Sprinkle drops and stray accesses as noise.
    task automatic test_random_fires();
        int beats;
        int n;
        int r0;
        int c0;
        beats = 0;
        n_scenes = 0;
        while (beats < RANDOM_BEATS)
        begin
            // Hold a stretch of scenes with no idling on either side.
            steady = (n_scenes >= 10 && n_scenes < 18);
            r0 = $urandom_range(0, 31);
            c0 = $urandom_range(0, 31);

            n = $urandom_range(1, 6);
            repeat (n)
            begin
                send_cmd(OP_WRITE, coord_t'(r0 + $urandom_range(0, 4) - 2),
                         coord_t'(c0 + $urandom_range(0, 4) - 2), fire_value());
            end
            beats += n;

            if ($urandom_range(0, 3) != 0)
            begin
                n = $urandom_range(1, 2);
                repeat (n)
                begin
                    send_cmd(OP_STEP, coord_t'($urandom_range(0, 31)),
                             coord_t'($urandom_range(0, 31)), cell_t'($urandom_range(0, 3)));
                end
                beats += n;
            end

            n = $urandom_range(3, 8);
            repeat (n)
            begin
                send_cmd(OP_READ, coord_t'(r0 + $urandom_range(0, 6) - 3),
                         coord_t'(c0 + $urandom_range(0, 6) - 3),
                         cell_t'($urandom_range(0, 3)));
            end
            beats += n;

            if ($urandom_range(0, 9) == 0)
            begin
                send_cmd(OP_UNUSED, coord_t'($urandom_range(0, 31)),
                         coord_t'($urandom_range(0, 31)), cell_t'($urandom_range(0, 3)));
            end
            if ($urandom_range(0, 9) == 0)
            begin
                send_cmd(opcode_t'($urandom_range(0, 1)), coord_t'($urandom_range(0, 31)),
                         coord_t'($urandom_range(0, 31)), cell_t'($urandom_range(0, 3)));
                beats++;
            end
            n_scenes++;
        end
        steady = 1'b0;
    endtask

    // Main sequence: reset once, run each test, drain, then give a full
    // generation's worth of cycles for any stray response before the verdict.
    initial
    begin
        n_errors = 0;
        n_writes = 0;
        n_reads = 0;
        n_steps = 0;
        n_dropped = 0;
        n_checked = 0;
        n_scenes = 0;
        steady = 1'b0;
        rsp_hold_cycles = 0;
        for (int r = 0; r < SIDE; r++)
        begin
            for (int c = 0; c < SIDE; c++)
            begin
                fire_grid[r][c] = CELL_INTACT;
            end
        end
        rst_n             <= 1'b0;
        cmd_if.valid      <= 1'b0;
        cmd_if.opcode     <= OP_READ;
        cmd_if.row        <= '0;
        cmd_if.col        <= '0;
        cmd_if.cell_value <= CELL_INTACT;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_state();
        test_write_read_extremes();
        test_unused_opcode();
        test_wrapping_spread();
        test_backpressure();
        test_random_fires();

        drain_responses();
        repeat (STEP_CYCLES) @(posedge clk);
        if (pending_rsp.size() != 0)
        begin
            report_mismatch($sformatf("%0d responses never arrived", pending_rsp.size()));
        end

        $display("Covered %0d writes, %0d reads, %0d generations and %0d dropped beats",
                 n_writes, n_reads, n_steps, n_dropped);
        $display("over %0d random fire scenes; %0d response beats checked, %0d mismatches",
                 n_scenes, n_checked, n_errors);
        if (n_errors == 0)
        begin
            $display("All tests passed");
        end
        else
        begin
            $display("Some tests failed");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial
    begin
        #8_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule

/* sim.f */
hw/rtl/fsca_pkg.sv
hw/rtl/fsca_if.sv
hw/rtl/fsca_front.sv
hw/rtl/fsca_back.sv
hw/rtl/fire_spread_cellular_automaton.sv
hw/rtl/fsca_checker.sv
tb/tb_top.sv
